>>> src/tccs_pkg.sv
`default_nettype none

package tccs_pkg;

    localparam int ROWS   = 16;
    localparam int COLS   = 32;
    localparam int CELLS  = ROWS * COLS;
    localparam int ROW_W  = 4;
    localparam int COL_W  = 5;
    localparam int ADDR_W = $clog2(CELLS);

    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_SPACE     = 8'd32;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef struct packed {
        logic [1:0]       op;
        logic [7:0]       char_code;
        logic [ROW_W-1:0] read_row;
        logic [COL_W-1:0] read_col;
    } cmd_t;

    typedef struct packed {
        logic [7:0]       cell_data;
        logic [ROW_W-1:0] cursor_row_out;
        logic [COL_W-1:0] cursor_col_out;
        logic             scrolled;
    } result_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } mem_wr_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        int unsigned lin;
        lin = int'(row) * COLS + int'(col);
        return lin[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> src/tccs_mem.sv
`default_nettype none

module tccs_mem
    import tccs_pkg::*;
(
    input  wire logic              clk,
    input  wire mem_wr_t           wr,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic [7:0]             rdata
);

    logic [7:0] mem [CELLS];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> src/text_console_cursor_scroll.sv
// Sequence: a put without scroll, an unused op or a zero byte strobes done from S_EXEC,
// a read after S_RDWAIT, a clear after the S_FILL sweep of the grid, and a put that
// scrolls after S_SCROLL and then S_FILL; the memory walks the grid one cell per cycle.
// Throughput: one command at a time; a new one is accepted in the cycle done is high.
// Reset clears the cursor and then sweeps the grid to zero, busy until the sweep ends.
// The done strobe is high for exactly one cycle; the receiver cannot stall it.
`default_nettype none

module text_console_cursor_scroll
    import tccs_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire cmd_t    cmd,
    output logic         busy,
    output logic         done,
    output result_t      result
);

    typedef enum logic [5:0] {
        S_INIT   = 6'b000001,
        S_IDLE   = 6'b000010,
        S_EXEC   = 6'b000100,
        S_RDWAIT = 6'b001000,
        S_SCROLL = 6'b010000,
        S_FILL   = 6'b100000
    } state_t;

    localparam logic [ADDR_W-1:0] MOVE_LAST = ADDR_W'(CELLS - COLS);
    localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);

    state_t            state_reg, state_next;
    cmd_t              req_reg, req_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic              scr_reg, scr_next;
    logic              done_reg, done_next;
    result_t           res_reg, res_next;

    mem_wr_t           mem_wr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        mem_rdata;

    logic [COL_W:0]    col_up;
    logic [ROW_W:0]    row_up;
    logic [ROW_W:0]    row_new;
    logic              read_in_grid;

    tccs_mem u_mem (
        .clk   (clk),
        .wr    (mem_wr),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    assign col_up       = {1'b0, col_reg} + (COL_W+1)'(1);
    assign row_up       = {1'b0, row_reg} + (ROW_W+1)'(1);
    assign read_in_grid = (int'(req_reg.read_row) < ROWS) && (int'(req_reg.read_col) < COLS);

    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        cnt_next   = cnt_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        scr_next   = scr_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        mem_wr     = '{we: 1'b0, addr: cnt_reg, data: 8'd0};
        mem_raddr  = cell_addr(req_reg.read_row, req_reg.read_col);
        row_new    = {1'b0, row_reg};

        unique case (state_reg)
            S_INIT, S_FILL:
            begin
                mem_wr = '{we: 1'b1, addr: cnt_reg, data: 8'd0};
                if (cnt_reg == CELL_LAST)
                begin
                    state_next = S_IDLE;
                    if (state_reg == S_FILL)
                    begin
                        done_next = 1'b1;
                        res_next  = '{cell_data: 8'd0, cursor_row_out: row_reg,
                                      cursor_col_out: col_reg, scrolled: scr_reg};
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = cmd;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                scr_next = 1'b0;
                res_next = '{cell_data: 8'd0, cursor_row_out: row_reg,
                             cursor_col_out: col_reg, scrolled: 1'b0};
                state_next = S_IDLE;
                done_next  = 1'b1;
                priority if (req_reg.op == OP_PUT)
                begin
                    priority if (req_reg.char_code == 8'd0)
                    begin
                        row_new = {1'b0, row_reg};
                    end
                    else if (req_reg.char_code == CH_BACKSPACE && col_reg != '0)
                    begin
                        col_next = col_reg - COL_W'(1);
                        mem_wr   = '{we: 1'b1, addr: cell_addr(row_reg, col_reg - COL_W'(1)),
                                     data: CH_SPACE};
                    end
                    else if (req_reg.char_code == CH_NEWLINE)
                    begin
                        row_new  = row_up;
                        col_next = '0;
                    end
                    else
                    begin
                        mem_wr = '{we: 1'b1, addr: cell_addr(row_reg, col_reg),
                                   data: req_reg.char_code};
                        if (int'(col_up) >= COLS)
                        begin
                            row_new  = row_up;
                            col_next = '0;
                        end
                        else
                        begin
                            col_next = col_up[COL_W-1:0];
                        end
                    end
                    if (int'(row_new) >= ROWS)
                    begin
                        row_next   = ROW_W'(ROWS - 1);
                        col_next   = '0;
                        scr_next   = 1'b1;
                        cnt_next   = '0;
                        state_next = S_SCROLL;
                        done_next  = 1'b0;
                    end
                    else
                    begin
                        row_next = row_new[ROW_W-1:0];
                    end
                    res_next.cursor_row_out = (int'(row_new) >= ROWS) ? ROW_W'(ROWS - 1)
                                                                      : row_new[ROW_W-1:0];
                    res_next.cursor_col_out = (int'(row_new) >= ROWS) ? '0 : col_next;
                end
                else if (req_reg.op == OP_READ)
                begin
                    state_next = S_RDWAIT;
                    done_next  = 1'b0;
                end
                else if (req_reg.op == OP_CLEAR)
                begin
                    cnt_next   = '0;
                    state_next = S_FILL;
                    done_next  = 1'b0;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_RDWAIT:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                res_next   = '{cell_data: read_in_grid ? mem_rdata : 8'd0,
                               cursor_row_out: row_reg, cursor_col_out: col_reg,
                               scrolled: 1'b0};
            end
            S_SCROLL:
            begin
                mem_raddr = cnt_reg + ADDR_W'(COLS);
                mem_wr    = '{we: (cnt_reg != '0), addr: cnt_reg - ADDR_W'(1),
                              data: mem_rdata};
                if (cnt_reg == MOVE_LAST)
                begin
                    state_next = S_FILL;
                end
                else
                begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cnt_reg   <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            scr_reg   <= 1'b0;
            done_reg  <= 1'b0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            scr_reg   <= scr_next;
            done_reg  <= done_next;
            res_reg   <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
    end

    // A command that is taken always leaves the idle state on the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not start");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == S_IDLE)
        else $error("result strobe outside idle");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // A scrolled result always leaves the cursor at the start of the last row.
    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.scrolled |->
            int'(result.cursor_row_out) == ROWS - 1 && result.cursor_col_out == '0)
        else $error("scroll left cursor elsewhere");

    a_data_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.cell_data != 8'd0 |-> $past(state_reg) == S_RDWAIT)
        else $error("cell data without a read");

endmodule

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import tccs_pkg::*;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam int         TEXT_ITEMS = 1400;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    cmd_t    cmd   = '0;
    logic    busy;
    logic    done;
    result_t result;

    logic [7:0]  shadow_grid [CELLS];
    int unsigned shadow_row;
    int unsigned shadow_col;
    result_t     pending_results [$];
    result_t     oldest_result;
    int          mismatches = 0;
    int          burst_left = 0;

    text_console_cursor_scroll i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always #1 clk = ~clk;

    initial
    begin
        #8_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic result_t console_predict(input cmd_t c);
        result_t     r;
        logic        scrolled_now;
        int unsigned idx;
        r = '0;
        scrolled_now = 1'b0;
        case (c.op)
            OP_PUT:
            begin
                if (c.char_code != 8'd0)
                begin
                    if (c.char_code == CH_BACKSPACE && shadow_col > 0)
                    begin
                        shadow_col--;
                        shadow_grid[shadow_row * COLS + shadow_col] = CH_SPACE;
                    end
                    else if (c.char_code == CH_NEWLINE)
                    begin
                        shadow_row++;
                        shadow_col = 0;
                    end
                    else
                    begin
                        shadow_grid[shadow_row * COLS + shadow_col] = c.char_code;
                        shadow_col++;
                        if (shadow_col >= COLS)
                        begin
                            shadow_col = 0;
                            shadow_row++;
                        end
                    end
                    if (shadow_row >= ROWS)
                    begin
                        for (idx = 0; idx < CELLS - COLS; idx++)
                            shadow_grid[idx] = shadow_grid[idx + COLS];
                        for (idx = CELLS - COLS; idx < CELLS; idx++)
                            shadow_grid[idx] = 8'd0;
                        shadow_row = ROWS - 1;
                        shadow_col = 0;
                        scrolled_now = 1'b1;
                    end
                end
            end
            OP_READ:
            begin
                if (int'(c.read_row) < ROWS && int'(c.read_col) < COLS)
                    r.cell_data = shadow_grid[int'(c.read_row) * COLS + int'(c.read_col)];
            end
            OP_CLEAR:
            begin
                for (idx = 0; idx < CELLS; idx++)
                    shadow_grid[idx] = 8'd0;
            end
            default:
            begin
            end
        endcase
        r.cursor_row_out = shadow_row[ROW_W-1:0];
        r.cursor_col_out = shadow_col[COL_W-1:0];
        r.scrolled       = scrolled_now;
        return r;
    endfunction

    function automatic cmd_t put_cmd(input logic [7:0] code);
        cmd_t c;
        c           = cmd_t'($urandom);
        c.op        = OP_PUT;
        c.char_code = code;
        return c;
    endfunction

    function automatic cmd_t read_cmd(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
        cmd_t c;
        c          = cmd_t'($urandom);
        c.op       = OP_READ;
        c.read_row = row;
        c.read_col = col;
        return c;
    endfunction

    function automatic cmd_t op_cmd(input logic [1:0] op);
        cmd_t c;
        c    = cmd_t'($urandom);
        c.op = op;
        return c;
    endfunction

    function automatic logic [7:0] text_char();
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom_range(1, 255));
        return 8'($urandom_range(8'h20, 8'h7e));
    endfunction

    task automatic send_cmd(input cmd_t c);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 7);
            repeat (gap)
            begin
                @(negedge clk);
                start <= 1'b0;
                cmd   <= cmd_t'($urandom);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(console_predict(c));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual %h", $time, result);
                mismatches++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                compare_field("cell_data", oldest_result.cell_data, result.cell_data);
                compare_field("cursor_row_out", oldest_result.cursor_row_out,
                              result.cursor_row_out);
                compare_field("cursor_col_out", oldest_result.cursor_col_out,
                              result.cursor_col_out);
                compare_field("scrolled", oldest_result.scrolled, result.scrolled);
            end
        end
    end

    task automatic test_after_reset();
        send_cmd(read_cmd(4'd15, 5'd31));
    endtask

    // Edit keys: extreme codes, the ignored zero byte, backspace on both sides of
    // column zero, newline and the unused op code.
    task automatic test_edit_keys();
        send_cmd(put_cmd(8'hff));
        send_cmd(put_cmd(8'h01));
        send_cmd(put_cmd(8'h00));
        send_cmd(put_cmd(CH_BACKSPACE));
        send_cmd(read_cmd(4'd0, 5'd1));
        send_cmd(put_cmd(CH_NEWLINE));
        send_cmd(put_cmd(CH_BACKSPACE));
        send_cmd(read_cmd(4'd1, 5'd0));
        send_cmd(op_cmd(OP_UNUSED));
    endtask

    task automatic test_clear();
        send_cmd(op_cmd(OP_CLEAR));
        send_cmd(read_cmd(4'd1, 5'd0));
    endtask

    task automatic test_newline_scroll();
        while (shadow_row < ROWS - 1)
            send_cmd(put_cmd(CH_NEWLINE));
        send_cmd(put_cmd(CH_NEWLINE));
        send_cmd(read_cmd(4'd15, 5'd31));
        wait_drained();
    endtask

    // Mostly lines of text, some long enough to wrap, mixed with reads, backspace
    // runs, clears, noise and full pauses.
    task automatic test_random_text();
        int sent;
        int kind;
        int len;
        sent = 0;
        while (sent < TEXT_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 55)
            begin
                len = $urandom_range(0, 20);
                if ($urandom_range(0, 7) == 0)
                    len = $urandom_range(30, 70);
                repeat (len)
                begin
                    send_cmd(put_cmd(text_char()));
                    sent++;
                end
                if ($urandom_range(0, 5) != 0)
                begin
                    send_cmd(put_cmd(CH_NEWLINE));
                    sent++;
                end
            end
            else if (kind < 85)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    if ($urandom_range(0, 1) == 0)
                        send_cmd(read_cmd(shadow_row[ROW_W-1:0], 5'($urandom)));
                    else
                        send_cmd(read_cmd(4'($urandom), 5'($urandom)));
                    sent++;
                end
            end
            else if (kind < 93)
            begin
                repeat ($urandom_range(1, 5))
                    send_cmd(put_cmd(CH_BACKSPACE));
            end
            else if (kind < 96)
            begin
                send_cmd(cmd_t'($urandom));
            end
            else if (kind < 98)
            begin
                send_cmd(op_cmd(OP_CLEAR));
                sent++;
            end
            else
            begin
                wait_drained();
            end
        end
    endtask

    initial
    begin
        foreach (shadow_grid[i])
            shadow_grid[i] = 8'd0;
        shadow_row = 0;
        shadow_col = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_after_reset();
        test_edit_keys();
        test_clear();
        test_newline_scroll();
        test_random_text();

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> text_console_cursor_scroll.f
src/tccs_pkg.sv
src/tccs_mem.sv
src/text_console_cursor_scroll.sv
bench/tb.sv
